FILE: design/anuc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package anuc_pkg;

  // Largest frame that is counted; later bytes only raise the oversize flag.
  localparam int unsigned MAX_FRAME_BYTES = 2097152;
  localparam int unsigned OFS_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam int unsigned START_W = 21;
  localparam int unsigned LEN_W   = 22;

  localparam logic [4:0] TYPE_MASK = 5'h1F;
  localparam logic [4:0] TYPE_IDR  = 5'd5;
  localparam logic [4:0] TYPE_SEI  = 5'd6;
  localparam logic [4:0] TYPE_SPS  = 5'd7;
  localparam logic [4:0] TYPE_PPS  = 5'd8;

  localparam logic [2:0] PREFIX_SHORT = 3'd3;
  localparam logic [2:0] PREFIX_LONG  = 3'd4;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_SUMMARY = 1'b1
  } event_kind_t;

  typedef struct packed {
    event_kind_t        event_kind;
    logic [4:0]         unit_type;
    logic [2:0]         prefix_length;
    logic [START_W-1:0] unit_start_offset;
    logic               keep_for_bootstrap;
    logic               frame_has_idr;
    logic               frame_has_config;
    logic [LEN_W-1:0]   frame_length;
    logic               oversize;
    logic               last;
  } result_t;

  // Results produced by one input byte: count, then first and second in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

FILE: design/annexb_nal_unit_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Annex B start code parser and NAL unit classifier.
// The input stream carries one frame byte per transaction in in_tdata, with
// in_tlast set on the last byte of the frame. The result stream carries one
// event per transaction: out_tuser is 0 for a NAL header event (type, start
// code length, start offset, keep flag) and 1 for the frame summary, which
// follows the last byte. out_tlast marks the final result caused by a byte.
// Each byte is classified in the cycle it is accepted and its results are
// written into a four-entry output queue, so a result is registered before
// it is visible. A byte that is both a NAL header and the frame's last byte
// produces two results, which leave in order, header event first.
// Throughput is one byte per cycle; in_tready drops only while the output
// queue holds more than two results, i.e. when the receiver stalls.
// Stalling the receiver never loses or reorders results; the input side
// simply waits. Synchronous reset clears the parser state and empties the
// queue; the block then expects the first byte of a new frame. After each
// frame summary the parser returns to the same cleared state by itself.

module annexb_nal_unit_classifier
  import anuc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // frame_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [4:0] unit_type, [7:5] prefix_length, [28:8] unit_start_offset,
  // [29] keep_for_bootstrap, [30] frame_has_idr, [31] frame_has_config,
  // [53:32] frame_length, [54] oversize, [55] zero padding
  output logic [55:0]      out_tdata,
  output logic             out_tuser,  // event_kind
  output logic             out_tlast   // last
);

  localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MAX_FRAME_BYTES);

  // Parser state.
  logic [1:0]         zero_run_r, zero_run_nxt;
  logic               header_pending_r, header_pending_nxt;
  logic [2:0]         pending_prefix_r, pending_prefix_nxt;
  logic [START_W-1:0] pending_start_r, pending_start_nxt;
  logic [OFS_W-1:0]   byte_offset_r, byte_offset_nxt;
  logic               idr_seen_r, idr_seen_nxt;
  logic               config_seen_r, config_seen_nxt;
  logic               overflowed_r, overflowed_nxt;

  logic               accept;
  logic               room;
  logic [4:0]         hdr_type;
  logic               keep;
  logic [2:0]         prefix;
  logic [OFS_W-1:0]   start_full;
  result_t            header_ev;
  result_t            summary_ev;
  result_t            head_result;
  push_t              push;

  assign in_tready = room;
  assign accept    = in_tvalid && in_tready;

  assign hdr_type = in_tdata[4:0] & TYPE_MASK;
  assign keep     = (hdr_type == TYPE_SEI) || (hdr_type == TYPE_SPS) ||
                    (hdr_type == TYPE_PPS);
  assign prefix   = (zero_run_r == 2'd3) ? PREFIX_LONG : PREFIX_SHORT;
  // The start code begins prefix bytes before the byte after the 01.
  assign start_full = byte_offset_r + OFS_W'(1) - OFS_W'(prefix);

  always_comb begin
    zero_run_nxt       = zero_run_r;
    header_pending_nxt = header_pending_r;
    pending_prefix_nxt = pending_prefix_r;
    pending_start_nxt  = pending_start_r;
    byte_offset_nxt    = byte_offset_r;
    idr_seen_nxt       = idr_seen_r;
    config_seen_nxt    = config_seen_r;
    overflowed_nxt     = overflowed_r;

    if (byte_offset_r >= MAX_OFS) begin
      // Bytes past the size limit are not counted and not searched.
      overflowed_nxt = 1'b1;
    end else begin
      byte_offset_nxt = byte_offset_r + OFS_W'(1);
      if (header_pending_r) begin
        if (hdr_type == TYPE_IDR) begin
          idr_seen_nxt = 1'b1;
        end
        if (keep) begin
          config_seen_nxt = 1'b1;
        end
        header_pending_nxt = 1'b0;
        zero_run_nxt       = 2'd0;
      end else if (in_tdata == 8'h00) begin
        if (zero_run_r != 2'd3) begin
          zero_run_nxt = zero_run_r + 2'd1;
        end
      end else if (in_tdata == 8'h01 && zero_run_r >= 2'd2) begin
        pending_prefix_nxt = prefix;
        pending_start_nxt  = START_W'(start_full);
        header_pending_nxt = 1'b1;
        zero_run_nxt       = 2'd0;
      end else begin
        zero_run_nxt = 2'd0;
      end
    end
  end

  always_comb begin
    header_ev                    = '0;
    header_ev.event_kind         = KIND_HEADER;
    header_ev.unit_type          = hdr_type;
    header_ev.prefix_length      = pending_prefix_r;
    header_ev.unit_start_offset  = pending_start_r;
    header_ev.keep_for_bootstrap = keep;
    header_ev.last               = !in_tlast;

    summary_ev                  = '0;
    summary_ev.event_kind       = KIND_SUMMARY;
    summary_ev.frame_has_idr    = idr_seen_nxt;
    summary_ev.frame_has_config = config_seen_nxt;
    summary_ev.frame_length     = LEN_W'(byte_offset_nxt);
    summary_ev.oversize         = overflowed_nxt;
    summary_ev.last             = 1'b1;
  end

  logic header_fires;
  assign header_fires = header_pending_r && (byte_offset_r < MAX_OFS);
  assign head_result  = header_fires ? header_ev : summary_ev;

  always_comb begin
    push        = '0;
    push.first  = head_result;
    push.second = summary_ev;
    if (accept) begin
      push.count = 2'({1'b0, header_fires} + {1'b0, in_tlast});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r       <= '0;
      header_pending_r <= 1'b0;
      pending_prefix_r <= '0;
      pending_start_r  <= '0;
      byte_offset_r    <= '0;
      idr_seen_r       <= 1'b0;
      config_seen_r    <= 1'b0;
      overflowed_r     <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        // The frame is closed: back to the cleared state.
        zero_run_r       <= '0;
        header_pending_r <= 1'b0;
        pending_prefix_r <= '0;
        pending_start_r  <= '0;
        byte_offset_r    <= '0;
        idr_seen_r       <= 1'b0;
        config_seen_r    <= 1'b0;
        overflowed_r     <= 1'b0;
      end else begin
        zero_run_r       <= zero_run_nxt;
        header_pending_r <= header_pending_nxt;
        pending_prefix_r <= pending_prefix_nxt;
        pending_start_r  <= pending_start_nxt;
        byte_offset_r    <= byte_offset_nxt;
        idr_seen_r       <= idr_seen_nxt;
        config_seen_r    <= config_seen_nxt;
        overflowed_r     <= overflowed_nxt;
      end
    end
  end

  result_t out_result;

  anuc_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tuser = out_result.event_kind;
  assign out_tlast = out_result.last;
  assign out_tdata = {1'b0,
                      out_result.oversize,
                      out_result.frame_length,
                      out_result.frame_has_config,
                      out_result.frame_has_idr,
                      out_result.keep_for_bootstrap,
                      out_result.unit_start_offset,
                      out_result.prefix_length,
                      out_result.unit_type};

endmodule

`default_nettype wire

FILE: design/anuc_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module anuc_out_fifo
  import anuc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire push_t   push,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  result_t            entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;
  logic               pop;
  logic [PTR_W-1:0]   wr_ptr_next1;

  assign room       = (count_r <= (PTR_W+1)'(DEPTH - 2));
  assign out_valid  = (count_r != '0);
  assign out_result = entry_r[rd_ptr_r];
  assign pop        = out_valid && out_ready;
  assign wr_ptr_next1 = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.count);
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry_r[wr_ptr_next1] <= push.second;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_annexb_nal_unit_classifier.sv
`timescale 1ns / 1ps

// Self-checking bench for the Annex B start code parser and NAL classifier.
//
// Frames of bytes are pushed through the input stream one transaction per
// byte, with in_tlast on the frame's last byte. A tracker object follows the
// same start code search as the block. For every byte transaction that it
// sees accepted, it queues the NAL header events and the frame summary that
// the byte should cause. Every result transaction is then compared, field by
// field, with the oldest queued event.
//
// A short directed part comes first. The random frames that follow are mostly
// well-formed sequences of start codes, header bytes and payload. The rest are
// noise frames and frames that end on a dangling start code. Both sides of the
// block idle at random, apart from one long stretch in which neither does.

module tb_annexb_nal_unit_classifier;
  import anuc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned STIM_ITEMS   = 1600;
  localparam int unsigned IDLE_PERCENT = 24;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Non-IDR coded slice.
  localparam logic [4:0] TYPE_SLICE = 5'd1;

  // Follows the parser state byte by byte and holds the events still owed by
  // the block, oldest first.
  class nal_event_tracker;
    logic [1:0]         zero_run;
    logic               header_pending;
    logic [2:0]         pending_prefix;
    logic [START_W-1:0] pending_start;
    logic [LEN_W-1:0]   byte_offset;
    logic               idr_seen;
    logic               config_seen;
    logic               overflowed;
    result_t            expected_events[$];
    int unsigned        errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      zero_run       = '0;
      header_pending = 1'b0;
      pending_prefix = '0;
      pending_start  = '0;
      byte_offset    = '0;
      idr_seen       = 1'b0;
      config_seen    = 1'b0;
      overflowed     = 1'b0;
    endfunction

    function int unsigned owed();
      return expected_events.size();
    endfunction

    // Works out the events that one accepted byte causes.
    function void note_byte(logic [7:0] data_byte, logic frame_end);
      result_t          ev;
      logic [4:0]       hdr_type;
      logic [LEN_W-1:0] pos;
      if (byte_offset >= MAX_FRAME_BYTES) begin
        // Bytes past the size limit are not counted and leave the search
        // untouched, so a pending header stays pending.
        overflowed = 1'b1;
      end else begin
        pos = byte_offset;
        byte_offset = byte_offset + 1'b1;
        if (header_pending) begin
          // The header byte never counts as a zero of the next start code.
          hdr_type              = data_byte[4:0] & TYPE_MASK;
          ev                    = '0;
          ev.event_kind         = KIND_HEADER;
          ev.unit_type          = hdr_type;
          ev.prefix_length      = pending_prefix;
          ev.unit_start_offset  = pending_start;
          ev.keep_for_bootstrap = (hdr_type == TYPE_SEI) || (hdr_type == TYPE_SPS) ||
                                  (hdr_type == TYPE_PPS);
          ev.last               = !frame_end;
          if (hdr_type == TYPE_IDR) begin
            idr_seen = 1'b1;
          end
          if (ev.keep_for_bootstrap) begin
            config_seen = 1'b1;
          end
          expected_events = {expected_events, ev};
          header_pending = 1'b0;
          zero_run       = '0;
        end else if (data_byte == 8'h00) begin
          if (zero_run != 2'd3) begin
            zero_run = zero_run + 1'b1;
          end
        end else if (data_byte == 8'h01 && zero_run >= 2'd2) begin
          pending_prefix = (zero_run == 2'd3) ? PREFIX_LONG : PREFIX_SHORT;
          pending_start  = START_W'(pos + 1 - pending_prefix);
          header_pending = 1'b1;
          zero_run       = '0;
        end else begin
          zero_run = '0;
        end
      end
      // A start code still waiting for its header at the frame end is dropped.
      if (frame_end) begin
        ev                  = '0;
        ev.event_kind       = KIND_SUMMARY;
        ev.frame_has_idr    = idr_seen;
        ev.frame_has_config = config_seen;
        ev.frame_length     = byte_offset;
        ev.oversize         = overflowed;
        ev.last             = 1'b1;
        expected_events = {expected_events, ev};
        clear_frame();
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_event(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d type %0d",
                 $time, got.event_kind, got.unit_type);
        errors++;
        return;
      end
      want = expected_events[0];
      expected_events.delete(0);
      compare_field("event_kind", want.event_kind, got.event_kind);
      compare_field("unit_type", want.unit_type, got.unit_type);
      compare_field("prefix_length", want.prefix_length, got.prefix_length);
      compare_field("unit_start_offset", want.unit_start_offset, got.unit_start_offset);
      compare_field("keep_for_bootstrap", want.keep_for_bootstrap, got.keep_for_bootstrap);
      compare_field("frame_has_idr", want.frame_has_idr, got.frame_has_idr);
      compare_field("frame_has_config", want.frame_has_config, got.frame_has_config);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("oversize", want.oversize, got.oversize);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  nal_event_tracker tracker = new();

  logic [7:0]  frame_bytes[$];
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;
  bit          steady     = 1'b0;   // set during the stretch with no idling
  result_t     seen_event;

  annexb_nal_unit_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, changing its mind only on falling edges.
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Both channels are observed at the rising edge. The input transaction is
  // noted before the result transaction is checked, so an event caused by a
  // byte is always queued before it can be compared.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        tracker.note_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        seen_event.event_kind         = event_kind_t'(out_tuser);
        seen_event.unit_type          = out_tdata[4:0];
        seen_event.prefix_length      = out_tdata[7:5];
        seen_event.unit_start_offset  = out_tdata[28:8];
        seen_event.keep_for_bootstrap = out_tdata[29];
        seen_event.frame_has_idr      = out_tdata[30];
        seen_event.frame_has_config   = out_tdata[31];
        seen_event.frame_length       = out_tdata[53:32];
        seen_event.oversize           = out_tdata[54];
        seen_event.last               = out_tlast;
        tracker.check_event(seen_event);
      end
    end
  end

  // Guards against a hang, for instance an event that never comes out.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("annexb_nal_unit_classifier test failed");
      $finish;
    end
  end

  // Random byte leaning heavily towards zero and one, so that start codes,
  // near misses and emulation-like patterns turn up inside payloads.
  function automatic logic [7:0] payload_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      return 8'h00;
    end else if (roll < 55) begin
      return 8'h01;
    end
    return 8'($urandom_range(255));
  endfunction

  // Builds one random frame in frame_bytes.
  task automatic make_frame();
    int unsigned shape;
    int unsigned units;
    logic [4:0]  hdr_type;
    frame_bytes.delete();
    shape = $urandom_range(99);
    if (shape < 12) begin
      // Noise frame with no deliberate structure.
      repeat ($urandom_range(1, 24)) frame_bytes = {frame_bytes, payload_byte()};
    end else begin
      units = $urandom_range(1, 5);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) frame_bytes = {frame_bytes, payload_byte()};
      end
      repeat (units) begin
        // Two zeros give a short start code, three or more a long one.
        repeat ($urandom_range(2, 5)) frame_bytes = {frame_bytes, 8'h00};
        frame_bytes = {frame_bytes, 8'h01};
        case ($urandom_range(7))
          0:       hdr_type = TYPE_IDR;
          1:       hdr_type = TYPE_SEI;
          2:       hdr_type = TYPE_SPS;
          3:       hdr_type = TYPE_PPS;
          4:       hdr_type = TYPE_SLICE;
          default: hdr_type = 5'($urandom_range(31));
        endcase
        frame_bytes = {frame_bytes, {3'($urandom_range(7)), hdr_type}};
        repeat ($urandom_range(0, 10)) frame_bytes = {frame_bytes, payload_byte()};
      end
      if (shape < 22) begin
        // Broken ending: a start code whose header never arrives.
        repeat ($urandom_range(2, 4)) frame_bytes = {frame_bytes, 8'h00};
        frame_bytes = {frame_bytes, 8'h01};
      end
    end
  endtask

  // Sends frame_bytes as byte transactions, the last one carrying in_tlast.
  // Called and returns at a falling edge.
  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= frame_bytes[i];
      in_tlast  <= (i == frame_bytes.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
      items_sent++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Long prefix, then a short one on a PPS header with its top bits set,
    // then five zeros that saturate the zero count before an IDR header which
    // is also the frame's last byte, so that byte owes two events.
    frame_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01,
                   8'hE8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65};
    send_frame();
    // A zero header byte must not count towards the following start code.
    frame_bytes = {8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
    send_frame();
    // Dangling start code: the frame ends on the 01.
    frame_bytes = {8'h00, 8'h00, 8'h01};
    send_frame();
    // Single-byte frame with every data bit high.
    frame_bytes = {8'hFF};
    send_frame();

    while (items_sent < STIM_ITEMS) begin
      steady = (items_sent >= 600) && (items_sent < 950);
      make_frame();
      send_frame();
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (tracker.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("annexb_nal_unit_classifier test passed");
    end else begin
      $display("annexb_nal_unit_classifier test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/anuc_pkg.sv
design/anuc_out_fifo.sv
design/annexb_nal_unit_classifier.sv
dv/tb_annexb_nal_unit_classifier.sv
